// File: design/swat_pkg.sv
package swat_pkg;

  typedef enum logic [1:0] {
    ACT_MATRIX = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_REF    = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic [2:0] REG_GAP_OPEN   = 3'd0;
  localparam logic [2:0] REG_GAP_EXTEND = 3'd1;
  localparam logic [2:0] REG_QUERY_LEN  = 3'd2;
  localparam logic [2:0] REG_MINUS_INF  = 3'd3;
  localparam logic [2:0] REG_SAT_CEIL   = 3'd4;

  localparam logic [1:0] ORG_ZERO = 2'd0;
  localparam logic [1:0] ORG_DIAG = 2'd1;
  localparam logic [1:0] ORG_DEL  = 2'd2;
  localparam logic [1:0] ORG_INS  = 2'd3;

  localparam logic signed [7:0] SCORE_MIN = -8'sd128;
  localparam logic signed [7:0] SCORE_MAX = 8'sd127;

  // minus infinity score after reset
  localparam logic signed [7:0] MINUS_INF_RESET = -8'sd117;

  // residue codes wrap at this size; the table index packs two codes
  localparam int ALPHABET_SIZE = 32;

  // classified item handed from front to back
  typedef struct packed {
    action_t    action;
    logic [4:0] row;
    logic [4:0] col;
    logic [7:0] score;
    logic [5:0] qidx;
    logic [4:0] code;
    logic       last;
  } cmd_t;

  function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
    if (v > 10'sd127) return SCORE_MAX;
    if (v < -10'sd128) return SCORE_MIN;
    return v[7:0];
  endfunction

  function automatic logic signed [7:0] smax(input logic signed [7:0] a,
                                             input logic signed [7:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: design/swat_front.sv
module swat_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,
  input  logic [1:0]        in_tuser,
  input  logic              in_tlast,
  output logic              q_valid,
  input  logic              q_ready,
  output swat_pkg::cmd_t    q_cmd
);

  // two-entry queue
  swat_pkg::cmd_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready && (in_tuser != swat_pkg::ACT_NONE);
  assign pop = q_valid && q_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].action <= swat_pkg::action_t'(in_tuser);
      mem_r[wp_r].row    <= in_tdata[4:0];
      mem_r[wp_r].col    <= in_tdata[9:5];
      mem_r[wp_r].score  <= in_tdata[17:10];
      mem_r[wp_r].qidx   <= in_tdata[23:18];
      mem_r[wp_r].code   <= in_tdata[28:24];
      mem_r[wp_r].last   <= in_tlast;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

endmodule

// File: design/swat_back.sv
module swat_back #(
  parameter int QUERY_MAX = 64,
  parameter int REFERENCE_COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  swat_pkg::cmd_t  q_cmd,
  input  logic [6:0]      gap_open,
  input  logic [6:0]      gap_extend,
  input  logic [6:0]      query_length,
  input  logic [7:0]      minus_inf,
  input  logic [6:0]      sat_ceiling,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [47:0]     out_tdata,
  output logic            out_tlast,
  output logic            out_tuser
);

  localparam int QW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
  localparam int AW = $clog2(swat_pkg::ALPHABET_SIZE);
  localparam int TD = swat_pkg::ALPHABET_SIZE * swat_pkg::ALPHABET_SIZE;
  localparam int TW = $clog2(TD);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CELL, ST_CLEAR} st_t;

  st_t st_r;
  logic [QW-1:0] i_r;
  logic [6:0]    len_r;
  logic [4:0]    code_r;
  logic          last_r;

  logic signed [7:0] sub_mem [TD];
  logic [AW-1:0]     qres_mem [QUERY_MAX];
  logic signed [7:0] h_mem [QUERY_MAX];
  logic signed [7:0] e_mem [QUERY_MAX];
  logic [QUERY_MAX-1:0] hv_r;  // entry written since clear; else reads reset value

  logic [AW-1:0]     qres_rd_r;
  logic signed [7:0] w_rd_r, hp_rd_r, e_rd_r;
  logic              hv_rd_r;
  logic signed [7:0] diag_r, hup_r, fup_r;
  logic signed [7:0] best_r;
  logic signed [7:0] clr_neg_r;  // e column value of entries not yet written
  logic [6:0]        bq_r;
  logic [REFERENCE_COUNT_BITS-1:0] bref_r, refc_r;
  logic              sat_r, bvalid_r;

  // query residue is prefetched one step ahead, then the table is read
  logic [QW-1:0]  ra;
  logic [QW-1:0]  qra;
  logic [TW-1:0]  taddr;
  logic [6:0]     len_c;
  assign ra = i_r;
  assign qra = (st_r == ST_IDLE) ? '0 : i_r + 1'b1;
  assign taddr = TW'({qres_rd_r, code_r[AW-1:0]});
  assign len_c = (query_length == 7'd0) ? 7'd1 :
                 (query_length > 7'(QUERY_MAX)) ? 7'(QUERY_MAX) : query_length;

  // cell arithmetic
  logic signed [7:0] hp, ep, e_opn, e_ext, e, hd, f_opn, f_ext, f, h;
  logic [1:0] origin;
  logic       col_done, upd, sat_n;
  logic signed [7:0] best_n;
  logic [6:0] bq_n;
  logic [REFERENCE_COUNT_BITS-1:0] bref_n;
  logic       bvalid_n;
  logic       obuf_free;
  logic       emit;
  logic [47:0] out_nxt;

  always_comb begin
    hp = hv_rd_r ? hp_rd_r : 8'sd0;
    ep = hv_rd_r ? e_rd_r : clr_neg_r;
    e_opn = swat_pkg::sat8(10'(hp) - $signed({3'b0, gap_open}));
    e_ext = swat_pkg::sat8(10'(ep) - $signed({3'b0, gap_extend}));
    e = swat_pkg::smax(e_opn, e_ext);
    hd = swat_pkg::sat8(10'(diag_r) + 10'(w_rd_r));
    f_opn = swat_pkg::sat8(10'(hup_r) - $signed({3'b0, gap_open}));
    f_ext = swat_pkg::sat8(10'(fup_r) - $signed({3'b0, gap_extend}));
    f = swat_pkg::smax(f_opn, f_ext);
    h = swat_pkg::smax(swat_pkg::smax(swat_pkg::smax(e, hd), f), 8'sd0);
    if (h == 8'sd0) origin = swat_pkg::ORG_ZERO;
    else if (h == hd) origin = swat_pkg::ORG_DIAG;
    else if (h == f) origin = swat_pkg::ORG_DEL;
    else origin = swat_pkg::ORG_INS;
    col_done = (7'(i_r) + 7'd1 == len_r);
    sat_n = sat_r || (h > $signed({1'b0, sat_ceiling}));
    upd = h > best_r;
    best_n = upd ? h : best_r;
    bq_n = upd ? 7'(i_r) : bq_r;
    bref_n = upd ? refc_r : bref_r;
    bvalid_n = bvalid_r || upd;
    // totals read as zero once saturated
    out_nxt = {sat_n,
               sat_n ? 16'd0 : 16'(bref_n),
               sat_n ? 7'd0 : (bvalid_n ? bq_n : len_r),
               sat_n ? 7'd0 : (best_n[7] ? 7'd0 : best_n[6:0]),
               f_opn > f_ext,
               e_opn > e_ext,
               origin,
               h[6:0],
               6'(i_r)};
  end

  assign obuf_free = !out_tvalid || out_tready;
  assign emit = (st_r == ST_CELL) && obuf_free;
  assign q_ready = (st_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_valid) begin
      if (q_cmd.action == swat_pkg::ACT_MATRIX)
        sub_mem[TW'({q_cmd.row[AW-1:0], q_cmd.col[AW-1:0]})] <= $signed(q_cmd.score);
      if (q_cmd.action == swat_pkg::ACT_QUERY && 32'(q_cmd.qidx) < QUERY_MAX)
        qres_mem[q_cmd.qidx[QW-1:0]] <= q_cmd.code[AW-1:0];
    end
    if (st_r == ST_IDLE || emit) qres_rd_r <= qres_mem[qra];
    if (st_r == ST_READ) begin
      w_rd_r  <= sub_mem[taddr];
      hp_rd_r <= h_mem[ra];
      e_rd_r  <= e_mem[ra];
      hv_rd_r <= hv_r[ra];
    end
    if (emit) begin
      h_mem[i_r] <= h;
      e_mem[i_r] <= e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      i_r <= '0;
      len_r <= 7'd1;
      code_r <= '0;
      last_r <= 1'b0;
      hv_r <= '0;
      diag_r <= '0;
      hup_r <= '0;
      fup_r <= '0;
      best_r <= swat_pkg::MINUS_INF_RESET;
      clr_neg_r <= swat_pkg::MINUS_INF_RESET;
      bq_r <= '0;
      bref_r <= '0;
      refc_r <= '0;
      sat_r <= 1'b0;
      bvalid_r <= 1'b0;
      out_tvalid <= 1'b0;
      out_tdata <= '0;
      out_tlast <= 1'b0;
      out_tuser <= 1'b0;
    end else begin
      out_tvalid <= emit || (out_tvalid && !out_tready);
      case (st_r)
        ST_IDLE: begin
          if (q_valid && q_cmd.action == swat_pkg::ACT_REF) begin
            st_r <= ST_READ;
            i_r <= '0;
            len_r <= len_c;
            code_r <= q_cmd.code;
            last_r <= q_cmd.last;
            diag_r <= '0;
            hup_r <= '0;
            fup_r <= $signed(minus_inf);
          end
        end
        ST_READ: st_r <= ST_CELL;
        ST_CELL: begin
          if (emit) begin
            hv_r[i_r] <= 1'b1;
            diag_r <= hp;
            hup_r <= h;
            fup_r <= f;
            sat_r <= sat_n;
            best_r <= best_n;
            bq_r <= bq_n;
            bref_r <= bref_n;
            bvalid_r <= bvalid_n;
            out_tlast <= col_done;
            out_tuser <= col_done && last_r;
            out_tdata <= out_nxt;
            if (col_done) begin
              refc_r <= refc_r + 1'b1;
              st_r <= last_r ? ST_CLEAR : ST_IDLE;
            end else begin
              i_r <= i_r + 1'b1;
              st_r <= ST_READ;
            end
          end
        end
        ST_CLEAR: begin
          hv_r <= '0;
          best_r <= $signed(minus_inf);
          clr_neg_r <= $signed(minus_inf);
          bq_r <= '0;
          bref_r <= '0;
          refc_r <= '0;
          sat_r <= 1'b0;
          bvalid_r <= 1'b0;
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_emit_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(st_r == ST_CELL)) else $error("result outside cell step");
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CELL |-> 7'(i_r) < len_r) else $error("cell index past length");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CLEAR |=> !sat_r && !bvalid_r) else $error("alignment not cleared");

endmodule

// File: design/smith_waterman_affine_trace_unit.sv
// Affine-gap local alignment with trace output. Load the substitution table
// (tuser 0) and query residues (tuser 1), then stream reference residues
// (tuser 2, tlast on the final one); tuser 3 is accepted and dropped. Each
// reference residue yields one result per query cell in query order, tlast on
// the last cell of a column and tuser on the last cell of the final column.
// Without output stalls each column takes the item from the input queue, then
// per cell a read state (registered read of the table and column memories)
// and a cell update; the final column of an alignment adds a clearing state.
// Loads are taken in the idle state. The user must write configuration only
// while no item is in flight; the block itself does not enforce this.
module smith_waterman_affine_trace_unit #(
  parameter int QUERY_MAX = 64,
  parameter int REFERENCE_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // matrix_row, matrix_col, matrix_score, query_index, residue_code, zero fill
  input  logic [31:0] in_tdata,
  // action
  input  logic [1:0]  in_tuser,
  // last_reference
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // query_position, cell_score, cell_origin, ins_from_open, del_from_open,
  // best_score, best_query_end, best_reference_end, saturated
  output logic [47:0] out_tdata,
  // column_done
  output logic        out_tlast,
  // alignment_done
  output logic        out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [6:0] gap_open_r, gap_extend_r, query_length_r, sat_ceiling_r;
  logic [7:0] minus_inf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_open_r <= 7'd10;
      gap_extend_r <= 7'd1;
      query_length_r <= 7'd64;
      minus_inf_r <= swat_pkg::MINUS_INF_RESET;
      sat_ceiling_r <= 7'd115;
    end else if (cfg_we) begin
      case (cfg_index)
        swat_pkg::REG_GAP_OPEN:   gap_open_r <= cfg_data[6:0];
        swat_pkg::REG_GAP_EXTEND: gap_extend_r <= cfg_data[6:0];
        swat_pkg::REG_QUERY_LEN:  query_length_r <= cfg_data[6:0];
        swat_pkg::REG_MINUS_INF:  minus_inf_r <= cfg_data;
        swat_pkg::REG_SAT_CEIL:   sat_ceiling_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic q_valid, q_ready;
  swat_pkg::cmd_t q_cmd;

  swat_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .q_valid, .q_ready, .q_cmd
  );

  swat_back #(
    .QUERY_MAX(QUERY_MAX),
    .REFERENCE_COUNT_BITS(REFERENCE_COUNT_BITS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .gap_open(gap_open_r), .gap_extend(gap_extend_r),
    .query_length(query_length_r), .minus_inf(minus_inf_r),
    .sat_ceiling(sat_ceiling_r),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

endmodule

// File: dv/tb_smith_waterman_affine_trace_unit.sv
`timescale 1ns / 100ps

module tb_smith_waterman_affine_trace_unit;

  // packed from the top of out_tdata down, then tlast and tuser
  typedef struct packed {
    logic        sat;
    logic [15:0] best_r;
    logic [6:0]  best_q;
    logic [6:0]  best;
    logic        del_open;
    logic        ins_open;
    logic [1:0]  origin;
    logic [6:0]  score;
    logic [5:0]  qpos;
    logic        col_done;
    logic        aln_done;
  } trace_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  smith_waterman_affine_trace_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // alignment model state
  int          gap_open_m, gap_ext_m, qlen_m, neg_m, pos_m;
  int          subst [0:1023];
  int          qres [0:63];
  int          hcol [0:63];
  int          ecol [0:63];
  int          best_m;
  int          best_q_m;
  int          best_r_m;
  int          ref_count_m;
  bit          sat_m;
  bit          best_seen_m;

  trace_t      trace_q[$];
  int          errors;
  int          n_results;
  int          n_items;
  int          n_columns;
  int          n_alignments;
  int          hold_reqs;
  int          hold_done;
  int          hold_left;
  bit          no_idle;
  int          alphabet [4] = '{0, 31, 5, 26};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("timeout at %0t", $time);
    $display("Regression FAIL");
    $finish;
  end

  function automatic int clamp8(int v);
    if (v > swat_pkg::SCORE_MAX) return swat_pkg::SCORE_MAX;
    if (v < swat_pkg::SCORE_MIN) return swat_pkg::SCORE_MIN;
    return v;
  endfunction

  function automatic int imax(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic void clear_alignment();
    for (int i = 0; i < 64; i++) begin
      hcol[i] = 0;
      ecol[i] = neg_m;
    end
    best_m = neg_m;
    best_q_m = 0;
    best_r_m = 0;
    ref_count_m = 0;
    sat_m = 1'b0;
    best_seen_m = 1'b0;
  endfunction

  // one dp column, one expected trace per query cell
  function automatic void score_column(int code, bit last);
    int len;
    int diag;
    int h_up;
    int f_up;
    int hp, e_o, e_x, e, hd, f_o, f_x, f, h;
    trace_t t;
    len = qlen_m;
    if (len < 1) len = 1;
    if (len > 64) len = 64;
    diag = 0;
    h_up = 0;
    f_up = neg_m;
    for (int i = 0; i < len; i++) begin
      hp = hcol[i];
      e_o = clamp8(hp - gap_open_m);
      e_x = clamp8(ecol[i] - gap_ext_m);
      e = imax(e_o, e_x);
      hd = clamp8(diag + subst[qres[i] * 32 + code]);
      f_o = clamp8(h_up - gap_open_m);
      f_x = clamp8(f_up - gap_ext_m);
      f = imax(f_o, f_x);
      h = imax(imax(imax(e, hd), f), 0);
      if (h == 0) t.origin = swat_pkg::ORG_ZERO;
      else if (h == hd) t.origin = swat_pkg::ORG_DIAG;
      else if (h == f) t.origin = swat_pkg::ORG_DEL;
      else t.origin = swat_pkg::ORG_INS;
      diag = hp;
      hcol[i] = h;
      ecol[i] = e;
      h_up = h;
      f_up = f;
      if (h > pos_m) sat_m = 1'b1;
      if (h > best_m) begin
        best_m = h;
        best_q_m = i;
        best_r_m = ref_count_m;
        best_seen_m = 1'b1;
      end
      t.qpos = i[5:0];
      t.score = h[6:0];
      t.ins_open = e_o > e_x;
      t.del_open = f_o > f_x;
      if (sat_m) begin
        t.best = '0;
        t.best_q = '0;
        t.best_r = '0;
      end else begin
        t.best = (best_m < 0) ? 7'd0 : best_m[6:0];
        t.best_q = best_seen_m ? best_q_m[6:0] : len[6:0];
        t.best_r = best_r_m[15:0];
      end
      t.sat = sat_m;
      t.col_done = (i + 1 == len);
      t.aln_done = (i + 1 == len) && last;
      trace_q.push_back(t);
    end
    ref_count_m = (ref_count_m + 1) & 16'hffff;
    n_columns++;
    if (last) begin
      n_alignments++;
      clear_alignment();
    end
  endfunction

  function automatic void model_item(swat_pkg::action_t act, logic [31:0] d, logic last);
    int s;
    case (act)
      swat_pkg::ACT_MATRIX: begin
        s = $signed(d[17:10]);
        subst[d[4:0] * 32 + d[9:5]] = s;
      end
      swat_pkg::ACT_QUERY: qres[d[23:18]] = d[28:24];
      swat_pkg::ACT_REF: score_column(d[28:24], last);
      default: ;
    endcase
  endfunction

  function automatic int idle_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(8, 30);
  endfunction

  // tvalid stays up after a transfer so the next item can follow at once
  task automatic send_item(swat_pkg::action_t act, logic [4:0] row, logic [4:0] col,
                           logic [7:0] score, logic [5:0] qidx,
                           logic [4:0] code, logic last);
    logic [31:0] d;
    int gap;
    d = {3'b000, code, qidx, score, col, row};
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= act;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    model_item(act, d, last);
    n_items++;
  endtask

  task automatic load_entry(int row, int col, int score);
    send_item(swat_pkg::ACT_MATRIX, 5'(row), 5'(col), 8'(score), 6'($urandom),
              5'($urandom), 1'($urandom));
  endtask

  task automatic load_query(int idx, int code);
    send_item(swat_pkg::ACT_QUERY, 5'($urandom), 5'($urandom), 8'($urandom), 6'(idx),
              5'(code), 1'($urandom));
  endtask

  task automatic send_ref(int code, bit last);
    send_item(swat_pkg::ACT_REF, 5'($urandom), 5'($urandom), 8'($urandom),
              6'($urandom), 5'(code), last);
  endtask

  function automatic int pick_code();
    return alphabet[$urandom_range(0, 3)];
  endfunction

  // loads cause no result, so let the block settle past a full column
  task automatic drain();
    in_tvalid <= 1'b0;
    while (trace_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      swat_pkg::REG_GAP_OPEN:   gap_open_m = value[6:0];
      swat_pkg::REG_GAP_EXTEND: gap_ext_m = value[6:0];
      swat_pkg::REG_QUERY_LEN:  qlen_m = value[6:0];
      swat_pkg::REG_MINUS_INF:  neg_m = $signed(value);
      swat_pkg::REG_SAT_CEIL:   pos_m = value[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic setup_tables();
    foreach (alphabet[r])
      foreach (alphabet[c])
        load_entry(alphabet[r], alphabet[c], (r == c) ? $urandom_range(2, 9)
                                                       : -$urandom_range(0, 6));
    for (int i = 0; i < 64; i++) load_query(i, pick_code());
  endtask

  task automatic test_directed();
    // extreme table scores drive saturation at both ends of the range
    load_entry(0, 0, 127);
    load_entry(31, 31, -128);
    load_query(0, 0);
    load_query(63, 31);
    send_item(swat_pkg::ACT_NONE, 5'h1f, 5'h1f, 8'hff, 6'h3f, 5'h1f, 1'b1);
    send_ref(0, 1'b0);
    send_ref(31, 1'b0);
    send_ref(0, 1'b1);
    load_entry(0, 0, 6);
    load_entry(31, 31, 7);
    load_query(0, 5);
    load_query(63, 26);
    send_ref(26, 1'b0);
    send_ref(5, 1'b0);
    send_ref(31, 1'b1);
    send_ref(0, 1'b1);
    drain();
  endtask

  task automatic run_alignments(int n_refs);
    int left;
    int run;
    left = n_refs;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0: load_entry(pick_code(), pick_code(), ($urandom_range(0, 3) == 0) ?
                      $urandom : $urandom_range(0, 12) - 6);
        1: load_query($urandom_range(0, 63), pick_code());
        2: send_item(swat_pkg::ACT_NONE, 5'($urandom), 5'($urandom), 8'($urandom),
                     6'($urandom), 5'($urandom), 1'($urandom));
        default: begin
          run = $urandom_range(1, 8);
          for (int k = 0; k < run; k++) send_ref(pick_code(), k == run - 1);
          left -= run;
        end
      endcase
    end
    drain();
  endtask

  task automatic test_config_sweep();
    cfg_write(swat_pkg::REG_QUERY_LEN, 8'd12);
    cfg_write(swat_pkg::REG_GAP_OPEN, 8'd0);
    cfg_write(swat_pkg::REG_GAP_EXTEND, 8'd0);
    cfg_write(swat_pkg::REG_MINUS_INF, 8'h80);
    cfg_write(swat_pkg::REG_SAT_CEIL, 8'd127);
    run_alignments(20);
    cfg_write(swat_pkg::REG_GAP_OPEN, 8'd127);
    cfg_write(swat_pkg::REG_GAP_EXTEND, 8'd127);
    cfg_write(swat_pkg::REG_MINUS_INF, 8'h00);
    cfg_write(swat_pkg::REG_SAT_CEIL, 8'd0);
    cfg_write(swat_pkg::REG_QUERY_LEN, 8'd1);
    run_alignments(20);
    cfg_write(swat_pkg::REG_GAP_OPEN, 8'd3);
    cfg_write(swat_pkg::REG_GAP_EXTEND, 8'd1);
    cfg_write(swat_pkg::REG_MINUS_INF, 8'h20);
    cfg_write(swat_pkg::REG_SAT_CEIL, 8'd40);
    cfg_write(swat_pkg::REG_QUERY_LEN, 8'd0);
    run_alignments(10);
    cfg_write(swat_pkg::REG_QUERY_LEN, 8'd100);
    cfg_write(swat_pkg::REG_MINUS_INF, 8'hf0);
    run_alignments(8);
  endtask

  task automatic test_backpressure();
    cfg_write(swat_pkg::REG_QUERY_LEN, 8'd64);
    cfg_write(swat_pkg::REG_SAT_CEIL, 8'd115);
    hold_reqs++;
    no_idle = 1'b1;
    for (int k = 0; k < 6; k++) send_ref(pick_code(), k == 5);
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_random();
    cfg_write(swat_pkg::REG_QUERY_LEN, 8'd9);
    cfg_write(swat_pkg::REG_GAP_OPEN, 8'd4);
    cfg_write(swat_pkg::REG_GAP_EXTEND, 8'd2);
    cfg_write(swat_pkg::REG_MINUS_INF, 8'h8b);
    no_idle = 1'b1;
    run_alignments(30);
    no_idle = 1'b0;
    cfg_write(swat_pkg::REG_QUERY_LEN, 8'd20);
    run_alignments(50);
  endtask

  // result checker
  always @(posedge clk) begin
    trace_t got;
    trace_t exp_t;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tlast, out_tuser};
      n_results++;
      if (trace_q.size() == 0) begin
        $display("%0t: unexpected transfer %p", $time, got);
        errors++;
      end else begin
        exp_t = trace_q.pop_front();
        if (got !== exp_t) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_t, got);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_done <= hold_reqs;
      hold_left <= 0;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_reqs;
      hold_left <= 600;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 29) == 0);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = swat_pkg::ACT_NONE;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = swat_pkg::REG_GAP_OPEN;
    cfg_data = '0;
    errors = 0;
    n_results = 0;
    n_items = 0;
    n_columns = 0;
    n_alignments = 0;
    hold_reqs = 0;
    no_idle = 1'b0;
    gap_open_m = 10;
    gap_ext_m = 1;
    qlen_m = 64;
    neg_m = -117;
    pos_m = 115;
    clear_alignment();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    setup_tables();
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    drain();
    $display("covered %0d items, %0d columns in %0d alignments, %0d traces checked",
             n_items, n_columns, n_alignments, n_results);
    $display("config extremes, saturation, odd query lengths and a long output stall");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
design/swat_pkg.sv
design/swat_front.sv
design/swat_back.sv
design/smith_waterman_affine_trace_unit.sv
dv/tb_smith_waterman_affine_trace_unit.sv
